// ===== rtl/mrh64_pkg.sv =====
// ----------------------------------------------------------------------------
// mrh64_pkg
// Shared constants and the controller-to-datapath command bundle for the
// multiply-rotate 64-bit hash.
// ----------------------------------------------------------------------------
package mrh64_pkg;

    // Request modes
    localparam logic [1:0] MODE_START       = 2'd0;
    localparam logic [1:0] MODE_WORD        = 2'd1;
    localparam logic [1:0] MODE_WORD_FINISH = 2'd2;
    localparam logic [1:0] MODE_FINISH      = 2'd3;

    // Hash constants
    localparam logic [63:0] HASH_K1 = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] HASH_K2 = 64'h6c62272e07bb0142;
    localparam logic [63:0] HASH_K3 = 64'h94d049bb133111eb;

    localparam int ABSORB_ROT  = 27;
    localparam int MIX_SHIFT_A = 33;
    localparam int MIX_SHIFT_B = 29;
    localparam int MIX_SHIFT_C = 32;

    // Partial-product phases of the 64x64 (mod 2^64) multiply
    localparam logic [1:0] MUL_LL = 2'd0;   // lo(x) * lo(k), full 64 bits
    localparam logic [1:0] MUL_LH = 2'd1;   // lo(x) * hi(k), into upper half
    localparam logic [1:0] MUL_HL = 2'd2;   // hi(x) * lo(k), into upper half

    typedef struct packed {
        logic       load_start;   // h <= K1 ^ length
        logic       load_word;    // x <= masked word
        logic       load_fin;     // x <= h ^ (h >> 33)
        logic       mix_absorb;   // x <= rotl(h ^ acc, 27)
        logic       commit;       // h <= acc + K3
        logic       mix_fin;      // x <= acc ^ (acc >> 29)
        logic       load_digest;  // digest <= acc ^ (acc >> 32)
        logic       mul_en;       // run one multiply phase
        logic [1:0] mul_phase;
        logic       mul_k2;       // 0: multiply by K1, 1: by K2
    } mrh64_cmd_t;

endpackage

// ===== rtl/mrh64_datapath.sv =====
// ----------------------------------------------------------------------------
// mrh64_datapath
// Running hash, multiply operand and accumulator registers, one shared
// 32x32 multiplier, and the xor/rotate/shift mixing steps.
// ----------------------------------------------------------------------------
module mrh64_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mrh64_pkg::mrh64_cmd_t  cmd,
    input  logic [31:0]            message_length,
    input  logic [63:0]            data_word,
    input  logic [3:0]             valid_bytes,
    output logic [63:0]            digest
);

    logic [63:0] h_reg;
    logic [63:0] h_next;
    logic [63:0] x_reg;
    logic [63:0] x_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [63:0] digest_reg;
    logic [63:0] digest_next;

    logic [63:0] word_masked;
    logic [63:0] mul_k;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] absorb_mix;

    // Byte mask: byte i kept when i < valid_bytes (zero keeps none)
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            word_masked[i*8 +: 8] = (4'(i) < valid_bytes) ? data_word[i*8 +: 8] : 8'd0;
        end
    end

    // Shared multiplier operand selection
    assign mul_k = cmd.mul_k2 ? mrh64_pkg::HASH_K2 : mrh64_pkg::HASH_K1;
    assign mul_a = (cmd.mul_phase == mrh64_pkg::MUL_HL) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b = (cmd.mul_phase == mrh64_pkg::MUL_LH) ? mul_k[63:32] : mul_k[31:0];
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    assign absorb_mix = h_reg ^ acc_reg;

    // Next-state logic for the registers
    always_comb
    begin
        h_next      = h_reg;
        x_next      = x_reg;
        acc_next    = acc_reg;
        digest_next = digest_reg;

        if (cmd.load_start)
        begin
            h_next = mrh64_pkg::HASH_K1 ^ {32'd0, message_length};
        end
        if (cmd.commit)
        begin
            h_next = acc_reg + mrh64_pkg::HASH_K3;
        end

        if (cmd.load_word)
        begin
            x_next = word_masked;
        end
        if (cmd.load_fin)
        begin
            x_next = h_reg ^ (h_reg >> mrh64_pkg::MIX_SHIFT_A);
        end
        if (cmd.mix_absorb)
        begin
            x_next = {absorb_mix[63-mrh64_pkg::ABSORB_ROT:0],
                      absorb_mix[63:64-mrh64_pkg::ABSORB_ROT]};
        end
        if (cmd.mix_fin)
        begin
            x_next = acc_reg ^ (acc_reg >> mrh64_pkg::MIX_SHIFT_B);
        end

        if (cmd.mul_en)
        begin
            case (cmd.mul_phase)
                mrh64_pkg::MUL_LL:
                begin
                    acc_next = mul_p;
                end
                default:
                begin
                    acc_next = {acc_reg[63:32] + mul_p[31:0], acc_reg[31:0]};
                end
            endcase
        end

        if (cmd.load_digest)
        begin
            digest_next = acc_reg ^ (acc_reg >> mrh64_pkg::MIX_SHIFT_C);
        end
    end

    // Running hash clears on reset; working registers are payload only
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        acc_reg    <= acc_next;
        digest_reg <= digest_next;
    end

    assign digest = digest_reg;

    // Running hash, zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= '0;
        end
        else
        begin
            h_reg <= h_next;
        end
    end

endmodule

// ===== rtl/mrh64_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrh64_ctrl
// Sequencer for the hash: accepts requests, steps the shared multiplier
// through its three partial products and drives the output handshake.
// ----------------------------------------------------------------------------
module mrh64_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             mode,
    output logic                   out_valid,
    input  logic                   out_stall,
    output mrh64_pkg::mrh64_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WK1     = 4'd1;
    localparam logic [3:0] S_WMIX    = 4'd2;
    localparam logic [3:0] S_WK2     = 4'd3;
    localparam logic [3:0] S_WCOMMIT = 4'd4;
    localparam logic [3:0] S_FLOAD   = 4'd5;
    localparam logic [3:0] S_FK1     = 4'd6;
    localparam logic [3:0] S_FMIX    = 4'd7;
    localparam logic [3:0] S_FK2     = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic       fin_reg;
    logic       fin_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       last_phase;
    logic       out_free;

    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign last_phase = (phase_reg == mrh64_pkg::MUL_HL);
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;

    // Sequencing and command decode
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.mul_phase  = phase_reg;

        case (state_reg)
            S_IDLE:
            begin
                phase_next = mrh64_pkg::MUL_LL;
                if (accept)
                begin
                    case (mode)
                        mrh64_pkg::MODE_START:
                        begin
                            cmd.load_start = 1'b1;
                        end
                        mrh64_pkg::MODE_WORD,
                        mrh64_pkg::MODE_WORD_FINISH:
                        begin
                            cmd.load_word = 1'b1;
                            fin_next      = (mode == mrh64_pkg::MODE_WORD_FINISH);
                            state_next    = S_WK1;
                        end
                        default:
                        begin
                            cmd.load_fin = 1'b1;
                            state_next   = S_FK1;
                        end
                    endcase
                end
            end
            S_WK1, S_WK2, S_FK1, S_FK2:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_k2 = (state_reg == S_WK2) || (state_reg == S_FK2);
                phase_next = last_phase ? mrh64_pkg::MUL_LL : phase_reg + 2'd1;
                if (last_phase)
                begin
                    state_next = state_reg + 4'd1;
                end
            end
            S_WMIX:
            begin
                cmd.mix_absorb = 1'b1;
                state_next     = S_WK2;
            end
            S_WCOMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = fin_reg ? S_FLOAD : S_IDLE;
            end
            S_FLOAD:
            begin
                cmd.load_fin = 1'b1;
                state_next   = S_FK1;
            end
            S_FMIX:
            begin
                cmd.mix_fin = 1'b1;
                state_next  = S_FK2;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_digest = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= mrh64_pkg::MUL_LL;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/multiply_rotate_hash64_core.sv =====
// ----------------------------------------------------------------------------
// multiply_rotate_hash64_core
// Multiply-rotate 64-bit message hash (xxh64-style, not standard XXH64).
// ----------------------------------------------------------------------------
// One request is taken at a time. A start request only loads the running
// hash; an absorb runs two multiplies with a rotate mix between them, then
// commits; a finish runs two multiplies with a shift mix between them, then
// loads the digest into the output register once the output is free; an
// absorb with finish runs both in turn. Each 64-bit multiply by a hash
// constant runs on the single shared 32x32 multiplier as three partial
// products, one per cycle. The running hash is zero after reset, and a
// finish leaves it unchanged, so repeated finishes give the same digest.
// ----------------------------------------------------------------------------
module multiply_rotate_hash64_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] message_length,
    input  logic [63:0] data_word,
    input  logic [3:0]  valid_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest
);

    mrh64_pkg::mrh64_cmd_t cmd;

    mrh64_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    mrh64_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .message_length (message_length),
        .data_word      (data_word),
        .valid_bytes    (valid_bytes),
        .digest         (digest)
    );

endmodule

// ===== bench/multiply_rotate_hash64_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiply_rotate_hash64_core_test
// Self-checking bench for the multiply-rotate 64-bit hash core. A directed
// table covers reset state, empty messages, byte masking and repeated
// finishes. Random messages and stray requests follow, with both handshakes
// throttled. Each digest is checked against the in-bench hash model or a table digest.
// ----------------------------------------------------------------------------
module multiply_rotate_hash64_core_test;

    import mrh64_pkg::*;

    localparam int DIRECTED_ROWS  = 22;
    localparam int RANDOM_ITEMS   = 1230;
    localparam int IDLE_PERCENT   = 18;
    localparam int CALM_FIRST     = 500;
    localparam int CALM_LAST      = 700;
    localparam int DRAIN_AT       = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] length;
        logic [63:0] word;
        logic [3:0]  count;
    } request_t;

    // Directed row: request plus an optional hand-written digest
    typedef struct packed {
        request_t    req;
        logic        known;
        logic [63:0] digest;
    } hash_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_START;
    logic [31:0] message_length = '0;
    logic [63:0] data_word = '0;
    logic [3:0]  valid_bytes = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] digest;

    logic [63:0] hash_state = '0;
    logic [63:0] pending_digests [$];
    logic [63:0] oldest_digest;
    bit          calm = 1'b0;
    bit          drained = 1'b0;
    int          sent_items = 0;
    int          message_count = 0;
    int          checked_digests = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;

    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

    hash_row_t directed_rows [DIRECTED_ROWS] = '{
        // finish straight out of reset: avalanche of zero is zero
        '{'{MODE_FINISH,      32'h0,        64'h0,                 4'd0},  1'b1, 64'h0},
        // finish again, unused fields at their maximum
        '{'{MODE_FINISH,      32'hffffffff, ONES,                  4'd15}, 1'b1, 64'h0},
        // zero valid bytes: word masked away but still absorbed
        '{'{MODE_WORD,        32'hffffffff, ONES,                  4'd0},  1'b0, 64'h0},
        '{'{MODE_WORD_FINISH, 32'h0,        64'h0123456789abcdef,  4'd0},  1'b0, 64'h0},
        // empty message
        '{'{MODE_START,       32'h0,        ONES,                  4'd15}, 1'b0, 64'h0},
        '{'{MODE_FINISH,      32'h0,        64'h0,                 4'd0},  1'b0, 64'h0},
        // longest length, full words, count above eight saturates
        '{'{MODE_START,       32'hffffffff, 64'h0,                 4'd0},  1'b0, 64'h0},
        '{'{MODE_WORD,        32'h0,        ONES,                  4'd8},  1'b0, 64'h0},
        '{'{MODE_WORD,        32'h0,        64'h5555555555555555,  4'd15}, 1'b0, 64'h0},
        '{'{MODE_WORD_FINISH, 32'h0,        ONES,                  4'd1},  1'b0, 64'h0},
        // finish leaves the state alone: same digest once more
        '{'{MODE_FINISH,      32'h0,        64'h0,                 4'd0},  1'b0, 64'h0},
        '{'{MODE_START,       32'd7,        64'h0,                 4'd0},  1'b0, 64'h0},
        '{'{MODE_WORD_FINISH, 32'hffffffff, 64'hfedcba9876543210,  4'd7},  1'b0, 64'h0},
        '{'{MODE_START,       32'd12,       64'h0,                 4'd0},  1'b0, 64'h0},
        '{'{MODE_WORD,        32'h0,        64'h8000000000000001,  4'd8},  1'b0, 64'h0},
        '{'{MODE_WORD_FINISH, 32'h0,        64'haaaaaaaaaaaaaaaa,  4'd4},  1'b0, 64'h0},
        '{'{MODE_START,       32'd24,       64'h0,                 4'd0},  1'b0, 64'h0},
        '{'{MODE_WORD,        32'h0,        ONES,                  4'd2},  1'b0, 64'h0},
        '{'{MODE_WORD,        32'h0,        ONES,                  4'd5},  1'b0, 64'h0},
        '{'{MODE_WORD_FINISH, 32'h0,        ONES,                  4'd6},  1'b0, 64'h0},
        '{'{MODE_WORD_FINISH, 32'h0,        64'h00ff00ff00ff00ff,  4'd9},  1'b0, 64'h0},
        '{'{MODE_FINISH,      32'hffffffff, ONES,                  4'd15}, 1'b0, 64'h0}
    };

    multiply_rotate_hash64_core i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .message_length (message_length),
        .data_word      (data_word),
        .valid_bytes    (valid_bytes),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digest         (digest)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hash model ------------------------------------------------------------

    // zero the bytes at or above the valid count; eight or more keeps all
    function automatic logic [63:0] keep_valid_bytes(logic [63:0] word, logic [3:0] count);
        logic [63:0] byte_mask;
        int          b;
        byte_mask = '0;
        for (b = 0; b < 8; b++)
        begin
            if (b < count)
                byte_mask[b*8 +: 8] = 8'hff;
        end
        return word & byte_mask;
    endfunction

    function automatic logic [63:0] absorb_word(logic [63:0] h, logic [63:0] word);
        logic [63:0] x;
        x = h ^ (word * HASH_K1);
        x = (x << ABSORB_ROT) | (x >> (64 - ABSORB_ROT));
        return x * HASH_K2 + HASH_K3;
    endfunction

    function automatic logic [63:0] avalanche_digest(logic [63:0] h);
        logic [63:0] x;
        x = h ^ (h >> MIX_SHIFT_A);
        x = x * HASH_K1;
        x = x ^ (x >> MIX_SHIFT_B);
        x = x * HASH_K2;
        return x ^ (x >> MIX_SHIFT_C);
    endfunction

    // advance the running hash; returns 1 when the request yields a digest
    function automatic bit predict_digest(request_t r, output logic [63:0] d);
        d = '0;
        if (r.mode == MODE_START)
        begin
            hash_state = HASH_K1 ^ {32'h0, r.length};
            return 1'b0;
        end
        if (r.mode == MODE_WORD || r.mode == MODE_WORD_FINISH)
            hash_state = absorb_word(hash_state, keep_valid_bytes(r.word, r.count));
        if (r.mode == MODE_WORD)
            return 1'b0;
        d = avalanche_digest(hash_state);
        return 1'b1;
    endfunction

    function automatic request_t random_request(logic [1:0] m);
        request_t r;
        r.mode   = m;
        r.length = $urandom;
        r.word   = {$urandom, $urandom};
        r.count  = 4'($urandom_range(15, 0));
        return r;
    endfunction

    // Request side ----------------------------------------------------------

    // drive one request, hold it until taken, then log its expected digest
    task automatic issue_request(request_t r, bit known, logic [63:0] known_digest);
        logic [63:0] d;
        calm = (sent_items >= CALM_FIRST && sent_items < CALM_LAST);
        while (!calm && $urandom_range(99, 0) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= r.mode;
        message_length <= r.length;
        data_word      <= r.word;
        valid_bytes    <= r.count;
        do
            @(posedge clk);
        while (in_stall);
        sent_items++;
        if (predict_digest(r, d))
            pending_digests.push_back(known ? known_digest : d);
    endtask

    // hold requests back until every digest in flight has come out
    task automatic wait_for_digests();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_digests.size() != 0);
    endtask

    initial
    begin
        request_t r;
        int       words;
        int       i;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < DIRECTED_ROWS; i++)
            issue_request(directed_rows[i].req, directed_rows[i].known,
                          directed_rows[i].digest);

        // random messages, with some stray requests mixed in
        while (sent_items < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            if ($urandom_range(9, 0) < 8)
            begin
                issue_request(random_request(MODE_START), 1'b0, '0);
                words = $urandom_range(5, 0);
                for (i = 0; i < words; i++)
                begin
                    r = random_request(MODE_WORD);
                    if ($urandom_range(9, 0) != 0)
                        r.count = 4'd8;
                    issue_request(r, 1'b0, '0);
                end
                if ($urandom_range(2, 0) != 0)
                begin
                    r = random_request(MODE_WORD_FINISH);
                    r.count = 4'($urandom_range(8, 1));
                end
                else
                    r = random_request(MODE_FINISH);
                issue_request(r, 1'b0, '0);
                if ($urandom_range(9, 0) == 0)
                    issue_request(random_request(MODE_FINISH), 1'b0, '0);
                message_count++;
                if (sent_items >= DRAIN_AT && !drained)
                begin
                    wait_for_digests();
                    drained = 1'b1;
                end
            end
            else
                issue_request(random_request(2'($urandom_range(3, 0))), 1'b0, '0);
        end

        // drain, then let the pipeline settle
        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("multiply_rotate_hash64_core: %0d requests, %0d random messages,",
                 sent_items, message_count);
        $display("  %0d digests checked, %0d mismatches", checked_digests, mismatch_count);
        if (mismatch_count == 0)
            $display("[multiply_rotate_hash64_core] OK");
        else
            $display("[multiply_rotate_hash64_core] ERROR");
        $finish;
    end

    // Result side -----------------------------------------------------------

    // random backpressure, none during the calm stretch
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99, 0) < IDLE_PERCENT);

    // compare each digest with the oldest one outstanding
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_digests.size() == 0)
            begin
                $error("digest: expected none, got %h", digest);
                mismatch_count++;
            end
            else
            begin
                oldest_digest = pending_digests.pop_front();
                checked_digests++;
                if (digest !== oldest_digest)
                begin
                    $error("digest: expected %h, got %h", oldest_digest, digest);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: give up after a long run of cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("multiply_rotate_hash64_core: no handshake for %0d cycles", idle_cycles);
            $display("[multiply_rotate_hash64_core] ERROR");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/mrh64_pkg.sv
rtl/mrh64_datapath.sv
rtl/mrh64_ctrl.sv
rtl/multiply_rotate_hash64_core.sv
bench/multiply_rotate_hash64_core_test.sv
